// ----- rtl/core/vcrs_pkg.sv -----
// ----------------------------------------------------------------------------
// vcrs_pkg: shared types, constants and microcode for the current shaper
// Control word layout, register map, status codes and the step program.
// ----------------------------------------------------------------------------
package vcrs_pkg;

	localparam int WHEEL_COUNT = 6;
	localparam int WHEEL_IDX_W = (WHEEL_COUNT > 1) ? $clog2(WHEEL_COUNT) : 1;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 12;
	localparam int POS_W       = 12;
	localparam int MA_W        = 10;

	localparam int VALUE_W = 16;
	localparam int ABS_W   = VALUE_W + 1;
	localparam int ACC_W   = 40;
	localparam int P_W     = 20;
	localparam int PROD_W  = 60;
	localparam int REF_W   = 18;
	localparam int CUR_W   = 11;
	localparam int PC_W    = 4;

	localparam int FRAC_SHIFT    = 12;
	localparam int OUT_SHIFT     = 44;
	localparam int PERCENT_SCALE = 25;

	// flow thresholds on |Q2.14| value: zero below 0.025, full above 0.97
	localparam int FLOW_ONE      = 16384;
	localparam int FLOW_ZERO_ABS = (FLOW_ONE + 39) / 40;
	localparam int FLOW_SAT_ABS  = (97 * FLOW_ONE) / 100;

	localparam logic signed [ACC_W-1:0] COEF_K1 = 40'sd50361;
	localparam logic signed [ACC_W-1:0] COEF_K2 = -40'sd8975690;
	localparam logic signed [ACC_W-1:0] COEF_K3 = 40'sd440649283;
	localparam logic signed [ACC_W-1:0] COEF_K4 = 40'sd9646472196;

	localparam logic signed [PROD_W-1:0] TRUNC_BIAS = (PROD_W'(1) <<< OUT_SHIFT) - PROD_W'(1);

	localparam logic [POS_W-1:0] RST_POS_LOW  = 12'd100;
	localparam logic [POS_W-1:0] RST_POS_HIGH = 12'd490;
	localparam logic [MA_W-1:0]  RST_LIMIT    = 10'd400;
	localparam logic [MA_W-1:0]  RST_DEADBAND = 10'd400;
	localparam logic [MA_W-1:0]  RST_FULL     = 10'd400;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_ACTUATE_ENABLE  = 3'd0,
		CFG_POS_LIMIT_EN    = 3'd1,
		CFG_POS_LOW_LIMIT   = 3'd2,
		CFG_POS_HIGH_LIMIT  = 3'd3,
		CFG_CURRENT_LIMIT   = 3'd4,
		CFG_DEADBAND_OFFSET = 3'd5,
		CFG_FLOW_FULL       = 3'd6
	} cfg_reg_t;

	typedef enum logic [1:0] {
		UNIT_FLOW     = 2'd0,
		UNIT_VELOCITY = 2'd1,
		UNIT_MA       = 2'd2,
		UNIT_INVALID  = 2'd3
	} unit_t;

	typedef enum logic {
		ACTION_SET   = 1'b0,
		ACTION_DRIVE = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_SAT    = 2'd1,
		ST_REJECT = 2'd2
	} status_t;

	typedef struct packed {
		logic             actuate_enable;
		logic             position_limit_enable;
		logic [POS_W-1:0] position_low_limit;
		logic [POS_W-1:0] position_high_limit;
		logic [MA_W-1:0]  current_limit;
		logic [MA_W-1:0]  deadband_offset;
		logic [MA_W-1:0]  flow_full_current;
	} cfg_t;

	typedef enum logic [3:0] {
		OP_NOP        = 4'd0,
		OP_INIT       = 4'd1,
		OP_MUL        = 4'd2,
		OP_ADD_K2     = 4'd3,
		OP_ADD_K3     = 4'd4,
		OP_ADD_K4     = 4'd5,
		OP_REF_POLY   = 4'd6,
		OP_REF_DIRECT = 4'd7,
		OP_SAT_STORE  = 4'd8,
		OP_ACTUATE    = 4'd9,
		OP_REJECT     = 4'd10
	} op_t;

	typedef enum logic [2:0] {
		C_NONE      = 3'd0,
		C_ALWAYS    = 3'd1,
		C_NOT_START = 3'd2,
		C_REJECT    = 3'd3,
		C_ACTUATE   = 3'd4,
		C_NOT_POLY  = 3'd5
	} cond_t;

	typedef struct packed {
		op_t             op;
		cond_t           cond;
		logic [PC_W-1:0] target;
	} ctrl_word_t;

	typedef struct packed {
		logic reject;
		logic actuate;
		logic not_poly;
	} flags_t;

	localparam logic [PC_W-1:0] STEP_IDLE       = 4'd0;
	localparam logic [PC_W-1:0] STEP_REF_DIRECT = 4'd12;
	localparam logic [PC_W-1:0] STEP_SAT_STORE  = 4'd13;
	localparam logic [PC_W-1:0] STEP_ACTUATE    = 4'd14;
	localparam logic [PC_W-1:0] STEP_REJECT     = 4'd15;

	function automatic ctrl_word_t ucode_rom(input logic [PC_W-1:0] pc);
		ctrl_word_t w;
		w = '{op: OP_NOP, cond: C_NONE, target: STEP_IDLE};
		case (pc)
			4'd0:  w = '{op: OP_NOP,        cond: C_NOT_START, target: STEP_IDLE};
			4'd1:  w = '{op: OP_NOP,        cond: C_REJECT,    target: STEP_REJECT};
			4'd2:  w = '{op: OP_NOP,        cond: C_ACTUATE,   target: STEP_ACTUATE};
			4'd3:  w = '{op: OP_INIT,       cond: C_NOT_POLY,  target: STEP_REF_DIRECT};
			4'd4:  w = '{op: OP_MUL,        cond: C_NONE,      target: STEP_IDLE};
			4'd5:  w = '{op: OP_ADD_K2,     cond: C_NONE,      target: STEP_IDLE};
			4'd6:  w = '{op: OP_MUL,        cond: C_NONE,      target: STEP_IDLE};
			4'd7:  w = '{op: OP_ADD_K3,     cond: C_NONE,      target: STEP_IDLE};
			4'd8:  w = '{op: OP_MUL,        cond: C_NONE,      target: STEP_IDLE};
			4'd9:  w = '{op: OP_ADD_K4,     cond: C_NONE,      target: STEP_IDLE};
			4'd10: w = '{op: OP_MUL,        cond: C_NONE,      target: STEP_IDLE};
			4'd11: w = '{op: OP_REF_POLY,   cond: C_ALWAYS,    target: STEP_SAT_STORE};
			4'd12: w = '{op: OP_REF_DIRECT, cond: C_NONE,      target: STEP_IDLE};
			4'd13: w = '{op: OP_SAT_STORE,  cond: C_ALWAYS,    target: STEP_IDLE};
			4'd14: w = '{op: OP_ACTUATE,    cond: C_ALWAYS,    target: STEP_IDLE};
			4'd15: w = '{op: OP_REJECT,     cond: C_ALWAYS,    target: STEP_IDLE};
			default: w = '{op: OP_NOP, cond: C_ALWAYS, target: STEP_IDLE};
		endcase
		return w;
	endfunction

endpackage

// ----- rtl/core/vcrs_sequencer.sv -----
// ----------------------------------------------------------------------------
// vcrs_sequencer: step counter and microcode table
// Fetches one control word per step and resolves conditional jumps.
// ----------------------------------------------------------------------------
module vcrs_sequencer import vcrs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  flags_t     flags,
	output logic       busy,
	output ctrl_word_t ctrl
);

	logic [PC_W-1:0] pc_q;
	logic            take;

	assign ctrl = ucode_rom(pc_q);
	assign busy = (pc_q != STEP_IDLE);

	always_comb begin
		case (ctrl.cond)
			C_NONE:      take = 1'b0;
			C_ALWAYS:    take = 1'b1;
			C_NOT_START: take = !start;
			C_REJECT:    take = flags.reject;
			C_ACTUATE:   take = flags.actuate;
			C_NOT_POLY:  take = flags.not_poly;
			default:     take = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_IDLE;
		end else if (take) begin
			pc_q <= ctrl.target;
		end else begin
			pc_q <= pc_q + PC_W'(1);
		end
	end

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("transaction accepted but sequencer stayed idle");

	a_rose_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("sequencer left idle without start");

	a_last_step: assert property (@(posedge clk) disable iff (!arst_n)
		busy && ctrl.cond == C_ALWAYS && ctrl.target == STEP_IDLE |=> !busy)
		else $error("final step did not return to idle");

endmodule

// ----- rtl/core/vcrs_datapath.sv -----
// ----------------------------------------------------------------------------
// vcrs_datapath: Horner multiplier, saturation, port split and wheel state
// Executes the operation of each control word; drives the result registers.
// ----------------------------------------------------------------------------
module vcrs_datapath import vcrs_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ctrl_word_t                ctrl,
	input  logic                      accept,
	input  cfg_t                      cfg,
	input  logic                      action,
	input  logic [2:0]                wheel,
	input  logic [1:0]                unit,
	input  logic signed [VALUE_W-1:0] reference_value,
	input  logic [POS_W-1:0]          position_mm,
	output flags_t                    flags,
	output logic                      done,
	output logic [2:0]                wheel_out,
	output logic [1:0]                status,
	output logic signed [CUR_W-1:0]   reference_ma,
	output logic [CUR_W-1:0]          current_a,
	output logic [CUR_W-1:0]          current_b,
	output logic                      drive_valid
);

	logic                      action_q;
	logic [2:0]                wheel_q;
	unit_t                     unit_q;
	logic signed [VALUE_W-1:0] value_q;
	logic [POS_W-1:0]          pos_q;

	logic signed [ACC_W-1:0]   acc_q;
	logic [P_W-1:0]            p_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [REF_W-1:0]   ref_raw_q;

	logic signed [CUR_W-1:0]   ref_mem_q [WHEEL_COUNT];
	logic [CUR_W-1:0]          pa_mem_q  [WHEEL_COUNT];
	logic [CUR_W-1:0]          pb_mem_q  [WHEEL_COUNT];

	logic                      done_q;
	logic [2:0]                wheel_out_q;
	status_t                   status_q;
	logic signed [CUR_W-1:0]   ref_out_q;
	logic [CUR_W-1:0]          cur_a_q;
	logic [CUR_W-1:0]          cur_b_q;
	logic                      drive_q;

	logic [WHEEL_IDX_W-1:0]    widx;
	logic                      wheel_ok;
	logic                      neg;
	logic [ABS_W-1:0]          abs_v;
	logic signed [PROD_W-1:0]  mul_a;
	logic signed [PROD_W-1:0]  mul_b;
	logic signed [PROD_W-1:0]  prod_adj;
	logic signed [REF_W-1:0]   poly_mag;
	logic signed [REF_W-1:0]   full_s;
	logic signed [REF_W-1:0]   direct_ref;
	logic signed [REF_W-1:0]   lim_s;
	logic signed [REF_W-1:0]   ref_sat;
	logic                      sat_hit;
	logic signed [CUR_W-1:0]   new_ref;
	logic [CUR_W-1:0]          new_pa;
	logic [CUR_W-1:0]          new_pb;
	logic                      cut_a;
	logic                      cut_b;
	logic [CUR_W-1:0]          act_pa;
	logic [CUR_W-1:0]          act_pb;

	assign widx     = WHEEL_IDX_W'(wheel_q);
	assign wheel_ok = (32'(wheel_q) < WHEEL_COUNT);
	assign neg      = value_q[VALUE_W-1];
	assign abs_v    = neg ? (ABS_W'(0) - {1'b1, value_q}) : {1'b0, value_q};

	assign flags.reject   = !wheel_ok || (action_q == ACTION_SET && unit_q == UNIT_INVALID);
	assign flags.actuate  = (action_q == ACTION_DRIVE);
	assign flags.not_poly = (unit_q != UNIT_FLOW) || (32'(abs_v) < FLOW_ZERO_ABS)
		|| (32'(abs_v) > FLOW_SAT_ABS);

	assign mul_a    = PROD_W'(acc_q);
	assign mul_b    = PROD_W'($signed({1'b0, p_q}));
	assign prod_adj = prod_q[PROD_W-1] ? (prod_q + TRUNC_BIAS) : prod_q;
	assign poly_mag = REF_W'(prod_adj >>> OUT_SHIFT);
	assign full_s   = $signed(REF_W'(cfg.flow_full_current));
	assign lim_s    = $signed(REF_W'(cfg.current_limit));

	always_comb begin
		case (unit_q)
			UNIT_FLOW: begin
				if (32'(abs_v) < FLOW_ZERO_ABS) begin
					direct_ref = '0;
				end else begin
					direct_ref = neg ? -full_s : full_s;
				end
			end
			UNIT_MA: direct_ref = REF_W'(value_q);
			default: direct_ref = '0;
		endcase
	end

	always_comb begin
		sat_hit = 1'b0;
		ref_sat = ref_raw_q;
		if (ref_raw_q > lim_s) begin
			ref_sat = lim_s;
			sat_hit = 1'b1;
		end else if (ref_raw_q < -lim_s) begin
			ref_sat = -lim_s;
			sat_hit = 1'b1;
		end
		new_ref = CUR_W'(ref_sat);
		new_pa  = '0;
		new_pb  = '0;
		if (new_ref > 0) begin
			new_pa = CUR_W'(new_ref) + CUR_W'(cfg.deadband_offset);
		end else if (new_ref < 0) begin
			new_pb = CUR_W'(-new_ref) + CUR_W'(cfg.deadband_offset);
		end
	end

	assign cut_a  = cfg.position_limit_enable && (pos_q < cfg.position_low_limit);
	assign cut_b  = cfg.position_limit_enable && !cut_a && (pos_q > cfg.position_high_limit);
	assign act_pa = cut_a ? '0 : pa_mem_q[widx];
	assign act_pb = cut_b ? '0 : pb_mem_q[widx];

	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= action;
			wheel_q  <= wheel;
			unit_q   <= unit_t'(unit);
			value_q  <= reference_value;
			pos_q    <= position_mm;
		end
		case (ctrl.op)
			OP_INIT: begin
				acc_q <= COEF_K1;
				p_q   <= P_W'(abs_v * PERCENT_SCALE);
			end
			OP_MUL:        prod_q    <= mul_a * mul_b;
			OP_ADD_K2:     acc_q     <= COEF_K2 + ACC_W'(prod_q >>> FRAC_SHIFT);
			OP_ADD_K3:     acc_q     <= COEF_K3 + ACC_W'(prod_q >>> FRAC_SHIFT);
			OP_ADD_K4:     acc_q     <= COEF_K4 + ACC_W'(prod_q >>> FRAC_SHIFT);
			OP_REF_POLY:   ref_raw_q <= neg ? -poly_mag : poly_mag;
			OP_REF_DIRECT: ref_raw_q <= direct_ref;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WHEEL_COUNT; i++) begin
				ref_mem_q[i] <= '0;
				pa_mem_q[i]  <= '0;
				pb_mem_q[i]  <= '0;
			end
		end else begin
			case (ctrl.op)
				OP_SAT_STORE: begin
					ref_mem_q[widx] <= new_ref;
					pa_mem_q[widx]  <= new_pa;
					pb_mem_q[widx]  <= new_pb;
				end
				OP_ACTUATE: begin
					pa_mem_q[widx] <= act_pa;
					pb_mem_q[widx] <= act_pb;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (ctrl.op == OP_SAT_STORE) || (ctrl.op == OP_ACTUATE)
				|| (ctrl.op == OP_REJECT);
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_SAT_STORE: begin
				wheel_out_q <= wheel_q;
				status_q    <= sat_hit ? ST_SAT : ST_OK;
				ref_out_q   <= new_ref;
				cur_a_q     <= new_pa;
				cur_b_q     <= new_pb;
				drive_q     <= 1'b0;
			end
			OP_ACTUATE: begin
				wheel_out_q <= wheel_q;
				status_q    <= ST_OK;
				ref_out_q   <= ref_mem_q[widx];
				cur_a_q     <= act_pa;
				cur_b_q     <= act_pb;
				drive_q     <= cfg.actuate_enable;
			end
			OP_REJECT: begin
				wheel_out_q <= wheel_q;
				status_q    <= ST_REJECT;
				ref_out_q   <= wheel_ok ? ref_mem_q[widx] : '0;
				cur_a_q     <= wheel_ok ? pa_mem_q[widx] : '0;
				cur_b_q     <= wheel_ok ? pb_mem_q[widx] : '0;
				drive_q     <= 1'b0;
			end
			default: begin
			end
		endcase
	end

	assign done         = done_q;
	assign wheel_out    = wheel_out_q;
	assign status       = status_q;
	assign reference_ma = ref_out_q;
	assign current_a    = cur_a_q;
	assign current_b    = cur_b_q;
	assign drive_valid  = drive_q;

	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held for two cycles");

	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && status_q == ST_SAT |->
		(ref_out_q == CUR_W'(lim_s) || ref_out_q == CUR_W'(-lim_s)))
		else $error("saturated reference not at current limit");

	a_one_port: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (cur_a_q == '0 || cur_b_q == '0))
		else $error("both valve ports driven");

endmodule

// ----- rtl/core/valve_current_reference_shaper_top.sv -----
// ----------------------------------------------------------------------------
// valve_current_reference_shaper_top: per-wheel valve current shaper
// Configuration registers, microcode sequencer and datapath.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; exactly one
// result follows, shown for a single cycle with done high, and it cannot be
// held off. The microcode program sets the time from accept to done: a flow
// set-reference in the polynomial band runs four multiplies and three
// coefficient adds through the one shared multiplier; other set-reference
// transactions, actuate and a rejected wheel or unit take shorter step
// sequences. busy drops in the same cycle that done is shown, so the next
// transaction may be taken then. Configuration writes apply at once.
module valve_current_reference_shaper_top import vcrs_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic                      cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	input  logic                      action,
	input  logic [2:0]                wheel,
	input  logic [1:0]                unit,
	input  logic signed [VALUE_W-1:0] reference_value,
	input  logic [POS_W-1:0]          position_mm,
	output logic                      done,
	output logic [2:0]                wheel_out,
	output logic [1:0]                status,
	output logic signed [CUR_W-1:0]   reference_ma,
	output logic [CUR_W-1:0]          current_a,
	output logic [CUR_W-1:0]          current_b,
	output logic                      drive_valid
);

	cfg_t       cfg_q;
	ctrl_word_t ctrl;
	flags_t     flags;
	logic       accept;

	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.actuate_enable        <= 1'b0;
			cfg_q.position_limit_enable <= 1'b1;
			cfg_q.position_low_limit    <= RST_POS_LOW;
			cfg_q.position_high_limit   <= RST_POS_HIGH;
			cfg_q.current_limit         <= RST_LIMIT;
			cfg_q.deadband_offset       <= RST_DEADBAND;
			cfg_q.flow_full_current     <= RST_FULL;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				CFG_ACTUATE_ENABLE:  cfg_q.actuate_enable        <= cfg_data[0];
				CFG_POS_LIMIT_EN:    cfg_q.position_limit_enable <= cfg_data[0];
				CFG_POS_LOW_LIMIT:   cfg_q.position_low_limit    <= cfg_data[POS_W-1:0];
				CFG_POS_HIGH_LIMIT:  cfg_q.position_high_limit   <= cfg_data[POS_W-1:0];
				CFG_CURRENT_LIMIT:   cfg_q.current_limit         <= cfg_data[MA_W-1:0];
				CFG_DEADBAND_OFFSET: cfg_q.deadband_offset       <= cfg_data[MA_W-1:0];
				CFG_FLOW_FULL:       cfg_q.flow_full_current     <= cfg_data[MA_W-1:0];
				default: begin
				end
			endcase
		end
	end

	vcrs_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.flags  (flags),
		.busy   (busy),
		.ctrl   (ctrl)
	);

	vcrs_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctrl            (ctrl),
		.accept          (accept),
		.cfg             (cfg_q),
		.action          (action),
		.wheel           (wheel),
		.unit            (unit),
		.reference_value (reference_value),
		.position_mm     (position_mm),
		.flags           (flags),
		.done            (done),
		.wheel_out       (wheel_out),
		.status          (status),
		.reference_ma    (reference_ma),
		.current_a       (current_a),
		.current_b       (current_b),
		.drive_valid     (drive_valid)
	);

endmodule
